// ===== src/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants for the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package mer_pkg;

	// width of the RGB color carried with each pixel
	localparam int COLOR_W = 24;

	// command kind decoded from the input tuser bit
	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	// back-end sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_RX,
		ST_SQ_RY,
		ST_RXRY,
		ST_INIT,
		ST_STEP,
		ST_SW_A,
		ST_SW_B,
		ST_SW_C,
		ST_SW_D,
		ST_SW_E,
		ST_SW_F,
		ST_EMIT
	} core_st_t;

	// request from the decision engine to the pixel emitter
	typedef struct packed {
		logic valid;
		logic done;
	} emit_req_t;

endpackage

`default_nettype wire

// ===== src/mer_front.sv =====
// ----------------------------------------------------------------------------
// mer_front
// Input side: accepts words, decodes start/step and queues them (two deep).
// ----------------------------------------------------------------------------
`default_nettype none

module mer_front
	import mer_pkg::*;
#(
	parameter int COORD_BITS  = 11,
	parameter int RADIUS_BITS = 10
) (
	input  wire logic                                                   clk,
	input  wire logic                                                   arst_n,
	input  wire logic                                                   s_tvalid,
	output logic                                                        s_tready,
	// center_x, center_y, radius_x, radius_y, zero fill
	input  wire logic [((2*COORD_BITS+2*RADIUS_BITS+7)/8)*8-1:0]        s_tdata,
	// func
	input  wire logic                                                   s_tuser,
	output logic                                                        q_valid,
	output op_t                                                         q_op,
	output logic [COORD_BITS-1:0]                                       q_cx,
	output logic [COORD_BITS-1:0]                                       q_cy,
	output logic [RADIUS_BITS-1:0]                                      q_rx,
	output logic [RADIUS_BITS-1:0]                                      q_ry,
	input  wire logic                                                   q_pop
);

	localparam int ENT_W = 1 + 2*COORD_BITS + 2*RADIUS_BITS;
	localparam int CXL   = 0;
	localparam int CYL   = COORD_BITS;
	localparam int RXL   = 2*COORD_BITS;
	localparam int RYL   = 2*COORD_BITS + RADIUS_BITS;

	logic [ENT_W-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             push;
	op_t              in_op;
	logic [ENT_W-1:0] rd_ent;

	// classify: tuser low means a new figure
	assign in_op    = s_tuser ? OP_STEP : OP_START;
	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= {in_op, s_tdata[RYL +: RADIUS_BITS], s_tdata[RXL +: RADIUS_BITS],
				s_tdata[CYL +: COORD_BITS], s_tdata[CXL +: COORD_BITS]};
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// head of queue
	assign rd_ent = mem_q[rd_ptr_q];
	assign q_op   = op_t'(rd_ent[ENT_W-1]);
	assign q_cx   = rd_ent[CXL +: COORD_BITS];
	assign q_cy   = rd_ent[CYL +: COORD_BITS];
	assign q_rx   = rd_ent[RXL +: RADIUS_BITS];
	assign q_ry   = rd_ent[RYL +: RADIUS_BITS];

endmodule

`default_nettype wire

// ===== src/mer_core.sv =====
// ----------------------------------------------------------------------------
// mer_core
// Decision engine: start setup, region-1/region-2 midpoint steps, one shared
// registered multiplier for the start and region-switch terms.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_core
	import mer_pkg::*;
#(
	parameter int COORD_BITS  = 11,
	parameter int RADIUS_BITS = 10
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_valid,
	input  wire op_t                    q_op,
	input  wire logic [COORD_BITS-1:0]  q_cx,
	input  wire logic [COORD_BITS-1:0]  q_cy,
	input  wire logic [RADIUS_BITS-1:0] q_rx,
	input  wire logic [RADIUS_BITS-1:0] q_ry,
	output logic                        q_pop,
	output emit_req_t                   emit_req,
	input  wire logic                   emit_ready,
	output logic [COORD_BITS-1:0]       pt_cx,
	output logic [COORD_BITS-1:0]       pt_cy,
	output logic [RADIUS_BITS-1:0]      pt_x,
	output logic [RADIUS_BITS-1:0]      pt_y
);

	localparam int R     = RADIUS_BITS;
	localparam int MOP_W = 2*R + 2;
	localparam int PRD_W = 2*MOP_W;
	localparam int DEC_W = 4*R + 5;
	localparam int PQ_W  = 3*R + 2;

	core_st_t st_q, st_d;

	logic [COORD_BITS-1:0]   cx_q, cy_q;
	logic [R-1:0]            rx_q, ry_q, x_q, y_q;
	logic [2*R-1:0]          rx2_q, ry2_q;
	logic [PQ_W-1:0]         p_q, q_q;
	logic signed [DEC_W-1:0] dec_q, acc_q;
	logic [MOP_W-1:0]        t_q;
	logic [PRD_W-1:0]        mul_q;
	logic                    region2_q, active_q, done_q;

	logic [MOP_W-1:0]        mul_a, mul_b;
	logic signed [DEC_W-1:0] mul4, rx2_4, ry2_4, rx2_d, p8, q8, k4, delta;
	logic [PQ_W-1:0]         ry2_pq, rx2_pq, p_n, q_n;
	logic                    dec_neg, dec_pos, mv_x, mv_y, to_switch;
	logic [R-1:0]            x_n, y_n;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else         st_q <= st_d;
	end

	// next state, queue pop, multiplier operands, emit request
	always_comb begin
		st_d          = st_q;
		q_pop         = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		emit_req.valid = 1'b0;
		emit_req.done  = done_q;
		case (st_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_op == OP_START) st_d = ST_SQ_RX;
					else if (active_q)   st_d = ST_STEP;
				end
			end
			ST_SQ_RX: begin
				mul_a = {{(MOP_W-R){1'b0}}, rx_q};
				mul_b = {{(MOP_W-R){1'b0}}, rx_q};
				st_d  = ST_SQ_RY;
			end
			ST_SQ_RY: begin
				mul_a = {{(MOP_W-R){1'b0}}, ry_q};
				mul_b = {{(MOP_W-R){1'b0}}, ry_q};
				st_d  = ST_RXRY;
			end
			ST_RXRY: begin
				mul_a = {2'b00, rx2_q};
				mul_b = {{(MOP_W-R){1'b0}}, ry_q};
				st_d  = ST_INIT;
			end
			ST_INIT: st_d = ST_EMIT;
			ST_STEP: st_d = to_switch ? ST_SW_A : ST_EMIT;
			ST_SW_A: begin
				// (2x+1)^2
				mul_a = {{(MOP_W-R-1){1'b0}}, x_q, 1'b1};
				mul_b = {{(MOP_W-R-1){1'b0}}, x_q, 1'b1};
				st_d  = ST_SW_B;
			end
			ST_SW_B: begin
				// (y-1)^2
				mul_a = {{(MOP_W-R){1'b0}}, y_q - {{(R-1){1'b0}}, 1'b1}};
				mul_b = {{(MOP_W-R){1'b0}}, y_q - {{(R-1){1'b0}}, 1'b1}};
				st_d  = ST_SW_C;
			end
			ST_SW_C: begin
				mul_a = {2'b00, ry2_q};
				mul_b = t_q;
				st_d  = ST_SW_D;
			end
			ST_SW_D: begin
				mul_a = {2'b00, rx2_q};
				mul_b = t_q;
				st_d  = ST_SW_E;
			end
			ST_SW_E: begin
				mul_a = {2'b00, rx2_q};
				mul_b = {2'b00, ry2_q};
				st_d  = ST_SW_F;
			end
			ST_SW_F: st_d = ST_STEP;
			ST_EMIT: begin
				emit_req.valid = 1'b1;
				if (emit_ready) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// widened terms
	assign mul4   = {mul_q[DEC_W-3:0], 2'b00};
	assign rx2_d  = {{(DEC_W-2*R){1'b0}}, rx2_q};
	assign rx2_4  = {{(DEC_W-2*R-2){1'b0}}, rx2_q, 2'b00};
	assign ry2_4  = {{(DEC_W-2*R-2){1'b0}}, ry2_q, 2'b00};
	assign ry2_pq = {{(PQ_W-2*R){1'b0}}, ry2_q};
	assign rx2_pq = {{(PQ_W-2*R){1'b0}}, rx2_q};

	// one midpoint step; p tracks ry^2*x and q tracks rx^2*y
	assign to_switch = !region2_q && (p_q > q_q);
	assign dec_neg   = dec_q[DEC_W-1];
	assign dec_pos   = !dec_neg && (dec_q != '0);
	assign mv_x      = region2_q ? !dec_pos : 1'b1;
	assign mv_y      = region2_q ? 1'b1 : !dec_neg;
	assign p_n       = mv_x ? (p_q + ry2_pq) : p_q;
	assign q_n       = mv_y ? (q_q - rx2_pq) : q_q;
	assign p8        = mv_x ? {{(DEC_W-PQ_W-3){1'b0}}, p_n, 3'b000} : '0;
	assign q8        = mv_y ? {{(DEC_W-PQ_W-3){1'b0}}, q_n, 3'b000} : '0;
	assign k4        = region2_q ? rx2_4 : ry2_4;
	assign delta     = p8 - q8 + k4;
	assign x_n       = x_q + {{(R-1){1'b0}}, mv_x};
	assign y_n       = y_q - {{(R-1){1'b0}}, mv_y};

	// shared multiplier
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (q_valid && (q_op == OP_START)) begin
					cx_q <= q_cx;
					cy_q <= q_cy;
					rx_q <= q_rx;
					ry_q <= q_ry;
					x_q  <= '0;
					y_q  <= q_ry;
				end
			end
			ST_SQ_RY: rx2_q <= mul_q[2*R-1:0];
			ST_RXRY:  ry2_q <= mul_q[2*R-1:0];
			ST_INIT: begin
				dec_q  <= ry2_4 - mul4 + rx2_d;
				p_q    <= '0;
				q_q    <= mul_q[PQ_W-1:0];
				done_q <= (rx_q == '0) || (ry_q == '0);
			end
			ST_STEP: begin
				if (!to_switch) begin
					dec_q  <= dec_q + delta;
					p_q    <= p_n;
					q_q    <= q_n;
					x_q    <= x_n;
					y_q    <= y_n;
					done_q <= (y_n == '0);
				end
			end
			ST_SW_B: t_q   <= mul_q[MOP_W-1:0];
			ST_SW_C: t_q   <= mul_q[MOP_W-1:0];
			ST_SW_D: acc_q <= {1'b0, mul_q};
			ST_SW_E: acc_q <= acc_q + mul4;
			ST_SW_F: dec_q <= acc_q - mul4;
			default: ;
		endcase
	end

	// figure status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region2_q <= 1'b0;
			active_q  <= 1'b0;
		end else begin
			case (st_q)
				ST_INIT: begin
					region2_q <= 1'b0;
					active_q  <= (rx_q != '0) && (ry_q != '0);
				end
				ST_STEP: if (!to_switch) active_q <= (y_n != '0);
				ST_SW_F: region2_q <= 1'b1;
				default: ;
			endcase
		end
	end

	assign pt_cx = cx_q;
	assign pt_cy = cy_q;
	assign pt_x  = x_q;
	assign pt_y  = y_q;

endmodule

`default_nettype wire

// ===== src/mer_emit.sv =====
// ----------------------------------------------------------------------------
// mer_emit
// Pixel emitter: mirrors one point into four pixels, registered output word.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_emit
	import mer_pkg::*;
#(
	parameter int COORD_BITS  = 11,
	parameter int RADIUS_BITS = 10
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire emit_req_t              emit_req,
	output logic                        emit_ready,
	input  wire logic [COORD_BITS-1:0]  pt_cx,
	input  wire logic [COORD_BITS-1:0]  pt_cy,
	input  wire logic [RADIUS_BITS-1:0] pt_x,
	input  wire logic [RADIUS_BITS-1:0] pt_y,
	input  wire logic [COLOR_W-1:0]     color,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// pixel_x, pixel_y, pixel_color, zero fill
	output logic [((2*(((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS)+2)
		+ COLOR_W + 7)/8)*8-1:0]        m_tdata,
	// last_of_step
	output logic                        m_tlast,
	// figure_done
	output logic                        m_tuser
);

	localparam int PIX_W = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;
	localparam int PAY_W = 2*PIX_W + COLOR_W;

	logic                    busy_q, done_q;
	logic [1:0]              k_q;
	logic [COORD_BITS-1:0]   cx_q, cy_q;
	logic [RADIUS_BITS-1:0]  x_q, y_q;
	logic                    m_tvalid_q, last_q, user_q;
	logic signed [PIX_W-1:0] px_q, py_q;
	logic [COLOR_W-1:0]      col_q;
	logic signed [PIX_W-1:0] cxe, cye, xe, ye, px, py;
	logic                    adv;

	assign emit_ready = !busy_q;
	assign adv        = busy_q && (!m_tvalid_q || m_tready);

	// mirror: x negated on pixels 1 and 2, y negated on pixels 2 and 3
	assign cxe = {{(PIX_W-COORD_BITS){1'b0}}, cx_q};
	assign cye = {{(PIX_W-COORD_BITS){1'b0}}, cy_q};
	assign xe  = {{(PIX_W-RADIUS_BITS){1'b0}}, x_q};
	assign ye  = {{(PIX_W-RADIUS_BITS){1'b0}}, y_q};
	assign px  = (k_q[0] ^ k_q[1]) ? (cxe - xe) : (cxe + xe);
	assign py  = k_q[1] ? (cye - ye) : (cye + ye);

	// point holding register
	always_ff @(posedge clk) begin
		if (emit_req.valid && !busy_q) begin
			cx_q   <= pt_cx;
			cy_q   <= pt_cy;
			x_q    <= pt_x;
			y_q    <= pt_y;
			done_q <= emit_req.done;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (adv) begin
			px_q   <= px;
			py_q   <= py;
			col_q  <= color;
			last_q <= (k_q == 2'd3);
			user_q <= done_q;
		end
	end

	// sequencing control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			k_q        <= 2'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (emit_req.valid && !busy_q) begin
				busy_q <= 1'b1;
				k_q    <= 2'd0;
			end else if (adv) begin
				k_q <= k_q + 2'd1;
				if (k_q == 2'd3) busy_q <= 1'b0;
			end
			if (adv)           m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_comb begin
		m_tdata            = '0;
		m_tdata[PAY_W-1:0] = {col_q, py_q, px_q};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = last_q;
	assign m_tuser  = user_q;

endmodule

`default_nettype wire

// ===== src/midpoint_ellipse_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_unit
// Axis-aligned midpoint ellipse rasterizer with exact integer decision.
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: cx, cy, rx, ry   tuser: func
// m_*       out  m_tvalid/m_tready  tdata: x, y, color      tlast, tuser: done
// cfg_*     in   cfg_we             cfg_wdata: draw color
//
// A start word runs its setup through the shared multiplier in the decision
// engine (rx^2, ry^2, then rx^2*ry); the step that enters region 2 first runs
// a multiply chain to reseed the decision and then repeats the step. Each
// command that draws yields four output words, one per cycle while m_tready
// does not stall the output, and the emitter takes the next point only after
// it has loaded the last word of the current one into its output register. A
// two-word queue lets the input side keep accepting while the engine or output
// stalls. Reset is asynchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_ellipse_rasterizer_unit
	import mer_pkg::*;
#(
	parameter int COORD_BITS  = 11,
	parameter int RADIUS_BITS = 10
) (
	input  wire logic                                              clk,
	input  wire logic                                              arst_n,
	input  wire logic                                              cfg_we,
	input  wire logic [COLOR_W-1:0]                                cfg_wdata,
	input  wire logic                                              s_tvalid,
	output logic                                                   s_tready,
	// center_x, center_y, radius_x, radius_y, zero fill
	input  wire logic [((2*COORD_BITS+2*RADIUS_BITS+7)/8)*8-1:0]   s_tdata,
	// func
	input  wire logic                                              s_tuser,
	output logic                                                   m_tvalid,
	input  wire logic                                              m_tready,
	// pixel_x, pixel_y, pixel_color, zero fill
	output logic [((2*(((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS)+2)
		+ COLOR_W + 7)/8)*8-1:0]                                   m_tdata,
	// last_of_step
	output logic                                                   m_tlast,
	// figure_done
	output logic                                                   m_tuser
);

	logic                   q_valid, q_pop, emit_ready;
	op_t                    q_op;
	logic [COORD_BITS-1:0]  q_cx, q_cy, pt_cx, pt_cy;
	logic [RADIUS_BITS-1:0] q_rx, q_ry, pt_x, pt_y;
	emit_req_t              emit_req;
	logic [COLOR_W-1:0]     color_q;

	// draw color register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     color_q <= '0;
		else if (cfg_we) color_q <= cfg_wdata;
	end

	mer_front #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_op     (q_op),
		.q_cx     (q_cx),
		.q_cy     (q_cy),
		.q_rx     (q_rx),
		.q_ry     (q_ry),
		.q_pop    (q_pop)
	);

	mer_core #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_op       (q_op),
		.q_cx       (q_cx),
		.q_cy       (q_cy),
		.q_rx       (q_rx),
		.q_ry       (q_ry),
		.q_pop      (q_pop),
		.emit_req   (emit_req),
		.emit_ready (emit_ready),
		.pt_cx      (pt_cx),
		.pt_cy      (pt_cy),
		.pt_x       (pt_x),
		.pt_y       (pt_y)
	);

	mer_emit #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.emit_req   (emit_req),
		.emit_ready (emit_ready),
		.pt_cx      (pt_cx),
		.pt_cy      (pt_cy),
		.pt_x       (pt_x),
		.pt_y       (pt_y),
		.color      (color_q),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

`ifndef SYNTHESIS
	// a full input side means the queue holds work for the engine
	a_full_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> q_valid)
		else $error("input stalled with empty queue");

	// the engine only pops a present word
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

	// a pending emit request is held until the emitter takes it
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_req.valid && !emit_ready) |=> emit_req.valid)
		else $error("emit request dropped");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the midpoint ellipse rasterizer. Commands (start and
// step words) are queued by a stimulus process and driven by a clocked driver
// with random gaps. On each accepted command that draws a local integer tracer
// advances its own copy of the ellipse state and queues the four mirrored
// pixels it expects. A clocked monitor stalls the output at random and checks
// every pixel word, field by field, against the oldest queued pixel.
// ----------------------------------------------------------------------------

module testbench;
	import mer_pkg::*;

	localparam int CMD_W = 48;
	localparam int PIX_W = 56;

	// one command word as the block sees it
	typedef struct packed {
		op_t         op;
		logic [10:0] cx;
		logic [10:0] cy;
		logic [9:0]  rx;
		logic [9:0]  ry;
	} draw_cmd_t;

	// tracer state for one ellipse
	typedef struct packed {
		logic [9:0]         cur_x;
		logic [9:0]         cur_y;
		logic signed [63:0] decision;
		bit                 region_two;
		bit                 active;
		logic [10:0]        ctr_x;
		logic [10:0]        ctr_y;
		logic [9:0]         rad_x;
		logic [9:0]         rad_y;
	} ellipse_state_t;

	// one expected or observed output word
	typedef struct packed {
		logic [12:0]        px;
		logic [12:0]        py;
		logic [COLOR_W-1:0] color;
		logic               last;
		logic               done;
	} pixel_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [COLOR_W-1:0] cfg_wdata = '0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [CMD_W-1:0]   s_tdata   = '0;
	logic               s_tuser   = 1'b0;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [PIX_W-1:0]   m_tdata;
	logic               m_tlast;
	logic               m_tuser;

	draw_cmd_t          cmd_backlog[$];
	pixel_t             pixel_queue[$];
	ellipse_state_t     plan_st;
	ellipse_state_t     trace_st;
	draw_cmd_t          held_cmd;
	logic [COLOR_W-1:0] paint_color = '0;
	int                 cmds_queued = 0;
	int                 cmds_taken  = 0;
	int                 live_cmds   = 0;
	int                 fault_count = 0;
	int                 send_gap    = 0;
	int                 recv_stall  = 0;

	midpoint_ellipse_rasterizer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	always #4 clk = ~clk;

	// gap length: mostly none, often short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 15);
		if (r < 9) return 0;
		if (r < 15) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// one midpoint decision step (or a start) on a tracer state
	task automatic march_ellipse(inout ellipse_state_t st, input draw_cmd_t c,
			output bit emits, output bit done);
		longint rx2, ry2, x, y;
		emits = 1'b0;
		done  = 1'b0;
		if (c.op == OP_START) begin
			st.ctr_x = c.cx;
			st.ctr_y = c.cy;
			st.rad_x = c.rx;
			st.rad_y = c.ry;
			rx2 = longint'(st.rad_x);
			ry2 = longint'(st.rad_y);
			y   = longint'(st.rad_y);
			rx2 = rx2 * rx2;
			ry2 = ry2 * ry2;
			st.cur_x      = '0;
			st.cur_y      = st.rad_y;
			st.region_two = 1'b0;
			st.decision   = 4 * ry2 - 4 * rx2 * y + rx2;
			done      = (st.rad_x == 0) || (st.rad_y == 0);
			st.active = !done;
			emits     = 1'b1;
		end else if (st.active) begin
			rx2 = longint'(st.rad_x);
			ry2 = longint'(st.rad_y);
			rx2 = rx2 * rx2;
			ry2 = ry2 * ry2;
			x   = longint'(st.cur_x);
			y   = longint'(st.cur_y);
			// leaving region 1: reseed the decision at the midpoint below
			if (!st.region_two && ry2 * x > rx2 * y) begin
				st.region_two = 1'b1;
				st.decision   = ry2 * (2 * x + 1) * (2 * x + 1)
					+ 4 * rx2 * (y - 1) * (y - 1) - 4 * rx2 * ry2;
			end
			if (!st.region_two) begin
				x = x + 1;
				if (st.decision < 0) begin
					st.decision = st.decision + 8 * ry2 * x + 4 * ry2;
				end else begin
					y = y - 1;
					st.decision = st.decision + 8 * ry2 * x - 8 * rx2 * y + 4 * ry2;
				end
			end else begin
				y = y - 1;
				if (st.decision > 0) begin
					st.decision = st.decision - 8 * rx2 * y + 4 * rx2;
				end else begin
					x = x + 1;
					st.decision = st.decision + 8 * ry2 * x - 8 * rx2 * y + 4 * rx2;
				end
			end
			if (y < 0) y = 0;
			st.cur_x = x[9:0];
			st.cur_y = y[9:0];
			done     = (st.cur_y == 0);
			if (done) st.active = 1'b0;
			emits = 1'b1;
		end
	endtask

	// k-th mirrored pixel: (+x,+y) (-x,+y) (-x,-y) (+x,-y)
	function automatic pixel_t mirror_pixel(ellipse_state_t st, int k,
			logic [COLOR_W-1:0] color, bit done);
		pixel_t      p;
		logic [12:0] cx, cy, ox, oy;
		cx = {2'b00, st.ctr_x};
		cy = {2'b00, st.ctr_y};
		ox = {3'b000, st.cur_x};
		oy = {3'b000, st.cur_y};
		p.px    = (k == 1 || k == 2) ? cx - ox : cx + ox;
		p.py    = (k >= 2) ? cy - oy : cy + oy;
		p.color = color;
		p.last  = (k == 3);
		p.done  = done;
		return p;
	endfunction

	// queue a command and track where the figure will be
	task automatic queue_cmd(input op_t op, input logic [10:0] cx, input logic [10:0] cy,
			input logic [9:0] rx, input logic [9:0] ry);
		draw_cmd_t c;
		bit        emits, done;
		c = '{op: op, cx: cx, cy: cy, rx: rx, ry: ry};
		march_ellipse(plan_st, c, emits, done);
		if (emits) live_cmds++;
		cmds_queued++;
		cmd_backlog.push_back(c);
	endtask

	// random payload on a step word; the block ignores it
	task automatic queue_step();
		queue_cmd(OP_STEP, 11'($urandom), 11'($urandom), 10'($urandom), 10'($urandom));
	endtask

	// start a figure and step it until it closes
	task automatic trace_figure(input logic [10:0] cx, input logic [10:0] cy,
			input logic [9:0] rx, input logic [9:0] ry);
		queue_cmd(OP_START, cx, cy, rx, ry);
		while (plan_st.active) queue_step();
	endtask

	// wait until the block is idle, then load a new draw color
	task automatic settle_block();
		while (cmds_taken != cmds_queued || pixel_queue.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_color(input logic [COLOR_W-1:0] c);
		settle_block();
		cfg_we    <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we      <= 1'b0;
		paint_color  = c;
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin
		bit emits, done;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				march_ellipse(trace_st, held_cmd, emits, done);
				if (emits)
					for (int k = 0; k < 4; k++)
						pixel_queue.push_back(mirror_pixel(trace_st, k, paint_color, done));
				cmds_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (cmd_backlog.size() != 0) begin
					held_cmd  = cmd_backlog.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {6'b0, held_cmd.ry, held_cmd.rx, held_cmd.cy, held_cmd.cx};
					s_tuser  <= held_cmd.op;
					send_gap  = pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// pixel monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		pixel_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = '{px: m_tdata[12:0], py: m_tdata[25:13], color: m_tdata[49:26],
					last: m_tlast, done: m_tuser};
				if (pixel_queue.size() == 0) begin
					fault_count++;
					$display("%0t: unexpected pixel word, actual %h", $time, got);
				end else begin
					want = pixel_queue.pop_front();
					if (got.px !== want.px) begin
						fault_count++;
						$display("%0t: pixel_x expected %h actual %h", $time, want.px, got.px);
					end
					if (got.py !== want.py) begin
						fault_count++;
						$display("%0t: pixel_y expected %h actual %h", $time, want.py, got.py);
					end
					if (got.color !== want.color) begin
						fault_count++;
						$display("%0t: pixel_color expected %h actual %h", $time,
							want.color, got.color);
					end
					if (got.last !== want.last) begin
						fault_count++;
						$display("%0t: last_of_step expected %b actual %b", $time,
							want.last, got.last);
					end
					if (got.done !== want.done) begin
						fault_count++;
						$display("%0t: figure_done expected %b actual %b", $time,
							want.done, got.done);
					end
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0) recv_stall = pick_gap();
			end
		end
	end

	// stimulus
	initial begin
		int base, choice, n;
		plan_st  = '0;
		trace_st = '0;
		held_cmd = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: idle steps, zero radii, extreme centers
		queue_step();
		queue_cmd(OP_START, 11'd0, 11'd0, 10'd0, 10'd1023);
		queue_cmd(OP_START, 11'd2047, 11'd2047, 10'd1023, 10'd0);
		queue_cmd(OP_START, 11'd0, 11'd0, 10'd0, 10'd0);
		queue_step();
		set_color(24'hFFFFFF);
		// pixels wrap below zero and past the top of the range
		trace_figure(11'd0, 11'd0, 10'd3, 10'd2);
		trace_figure(11'd2047, 11'd2047, 10'd2, 10'd3);
		// restart while drawing
		queue_cmd(OP_START, 11'd1024, 11'd1024, 10'd1023, 10'd1023);
		repeat (3) queue_step();
		trace_figure(11'd5, 11'd2040, 10'd1, 10'd1);
		// narrow figure drops into region 2 after its first step
		trace_figure(11'd100, 11'd100, 10'd1, 10'd6);
		queue_step();

		// random: mostly whole small figures, some abandoned ones, some noise
		set_color(24'h000000);
		base = live_cmds;
		while (live_cmds - base < 100) begin
			if ($urandom_range(0, 24) == 0) set_color(24'($urandom));
			choice = $urandom_range(0, 9);
			if (choice < 7) begin
				trace_figure(11'($urandom), 11'($urandom), 10'($urandom_range(0, 12)),
					10'($urandom_range(0, 12)));
				if ($urandom_range(0, 3) == 0) queue_step();
			end else if (choice < 9) begin
				queue_cmd(OP_START, 11'($urandom), 11'($urandom), 10'($urandom),
					10'($urandom));
				n = $urandom_range(1, 8);
				repeat (n) queue_step();
			end else begin
				queue_step();
			end
		end

		settle_block();
		if (fault_count == 0 && pixel_queue.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog
	initial begin
		#8000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
src/mer_pkg.sv
src/mer_front.sv
src/mer_core.sv
src/mer_emit.sv
src/midpoint_ellipse_rasterizer_unit.sv
bench/testbench.sv
